// ===== hdl/asfp_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// asfp_pkg
// Shared widths, register indexes, reset values and record types of the
// addressed serial frame parser.
// ----------------------------------------------------------------------------
package asfp_pkg;

	localparam int BYTE_W = 8;
	localparam int CFG_IDX_W = 3;
	localparam int KIND_W = 2;

	typedef logic [BYTE_W-1:0] byte_t;

	// register indexes on the configuration port
	localparam logic [CFG_IDX_W-1:0] CFG_START_MARKER = 3'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_OWN_ADDRESS = 3'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_SUB_LOW = 3'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_SUB_HIGH = 3'd3;
	localparam logic [CFG_IDX_W-1:0] CFG_PING_CODE = 3'd4;

	localparam byte_t RST_START_MARKER = 8'd77;
	localparam byte_t RST_OWN_ADDRESS = 8'd1;
	localparam byte_t RST_SUB_LOW = 8'd1;
	localparam byte_t RST_SUB_HIGH = 8'd255;
	localparam byte_t RST_PING_CODE = 8'd128;

	localparam byte_t SYSTEM_ADDR = 8'h00;

	typedef enum logic [KIND_W-1:0] {
		KIND_DEVICE = 2'd0,
		KIND_SYSTEM = 2'd1,
		KIND_PONG = 2'd2
	} kind_t;

	typedef struct packed {
		byte_t start_marker;
		byte_t own_address;
		byte_t sub_low;
		byte_t sub_high;
		byte_t ping_code;
	} cfg_t;

	typedef struct packed {
		kind_t kind;
		byte_t sub_address;
		byte_t byte_index;
		byte_t body_byte;
		logic  last;
	} res_t;

	// handshake between the byte register and the result register
	typedef struct packed {
		logic step;
	} flow_t;

endpackage

// ===== hdl/asfp_rx_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// asfp_rx_if
// Channel of received bytes: valid, ready and one byte.
// ----------------------------------------------------------------------------
interface asfp_rx_if;
	logic valid;
	logic ready;
	logic [asfp_pkg::BYTE_W-1:0] rx_byte;

	modport source (output valid, output rx_byte, input ready);
	modport sink (input valid, input rx_byte, output ready);
endinterface

// ===== hdl/asfp_res_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// asfp_res_if
// Channel of parsed results: forwarded body bytes and pong requests.
// ----------------------------------------------------------------------------
interface asfp_res_if;
	logic valid;
	logic ready;
	logic [asfp_pkg::KIND_W-1:0] kind;
	logic [asfp_pkg::BYTE_W-1:0] sub_address;
	logic [asfp_pkg::BYTE_W-1:0] byte_index;
	logic [asfp_pkg::BYTE_W-1:0] body_byte;
	logic last;

	modport source (output valid, output kind, output sub_address, output byte_index,
		output body_byte, output last, input ready);
	modport sink (input valid, input kind, input sub_address, input byte_index,
		input body_byte, input last, output ready);
endinterface

// ===== hdl/asfp_cfg_regs.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// asfp_cfg_regs
// Configuration registers written through a plain indexed write port.
// ----------------------------------------------------------------------------
module asfp_cfg_regs (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	input  wire logic                           cfg_we,
	input  wire logic [asfp_pkg::CFG_IDX_W-1:0] cfg_index,
	input  wire asfp_pkg::byte_t                cfg_data,
	output asfp_pkg::cfg_t                      cfg
);

	asfp_pkg::cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.start_marker <= asfp_pkg::RST_START_MARKER;
			cfg_q.own_address <= asfp_pkg::RST_OWN_ADDRESS;
			cfg_q.sub_low <= asfp_pkg::RST_SUB_LOW;
			cfg_q.sub_high <= asfp_pkg::RST_SUB_HIGH;
			cfg_q.ping_code <= asfp_pkg::RST_PING_CODE;
		end else if (cfg_we) begin
			unique case (cfg_index)
				asfp_pkg::CFG_START_MARKER: cfg_q.start_marker <= cfg_data;
				asfp_pkg::CFG_OWN_ADDRESS: cfg_q.own_address <= cfg_data;
				asfp_pkg::CFG_SUB_LOW: cfg_q.sub_low <= cfg_data;
				asfp_pkg::CFG_SUB_HIGH: cfg_q.sub_high <= cfg_data;
				asfp_pkg::CFG_PING_CODE: cfg_q.ping_code <= cfg_data;
				default: ;  // writes past the register list are dropped
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule
`default_nettype wire

// ===== hdl/asfp_in_stage.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// asfp_in_stage
// Input byte register; refills in the same cycle that its byte is consumed.
// ----------------------------------------------------------------------------
module asfp_in_stage (
	input  wire logic       clk,
	input  wire logic       arst_n,
	asfp_rx_if.sink         rx,
	input  wire logic       advance,
	output asfp_pkg::flow_t flow,
	output asfp_pkg::byte_t byte_s1
);

	logic            vld_s1;
	asfp_pkg::byte_t data_s1;

	assign rx.ready = !vld_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (rx.ready) begin
			vld_s1 <= rx.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (rx.valid && rx.ready) begin
			data_s1 <= rx.rx_byte;
		end
	end

	assign flow.step = vld_s1 && advance;
	assign byte_s1 = data_s1;

endmodule
`default_nettype wire

// ===== hdl/asfp_frame_fsm.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// asfp_frame_fsm
// Frame state machine: start hunt, address and sub-address filters, length
// and body bytes. Produces at most one result per byte.
// ----------------------------------------------------------------------------
module asfp_frame_fsm (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire asfp_pkg::flow_t flow,
	input  wire asfp_pkg::byte_t byte_s1,
	input  wire asfp_pkg::cfg_t  cfg,
	output logic                 res_vld,
	output asfp_pkg::res_t       res
);

	typedef enum logic [2:0] {
		PH_HUNT = 3'd0,
		PH_ADDR = 3'd1,
		PH_SUB  = 3'd2,
		PH_LEN  = 3'd3,
		PH_BODY = 3'd4
	} phase_t;

	phase_t          phase_q, phase_nxt;
	logic            sys_q, sys_nxt;
	logic            ping_q, ping_nxt;
	asfp_pkg::byte_t sub_q, sub_nxt;
	asfp_pkg::byte_t len_q, len_nxt;
	asfp_pkg::byte_t pos_q, pos_nxt;

	logic is_last;
	logic ping_now;
	logic sub_ok;

	assign is_last = ({1'b0, pos_q} + 9'd1) >= {1'b0, len_q};
	assign ping_now = (pos_q == '0) ? (sys_q && byte_s1 == cfg.ping_code) : ping_q;
	// an empty range (low above high) leaves only sub-address zero
	assign sub_ok = (byte_s1 == '0) || (byte_s1 >= cfg.sub_low && byte_s1 <= cfg.sub_high);

	always_comb begin
		phase_nxt = phase_q;
		sys_nxt = sys_q;
		ping_nxt = ping_q;
		sub_nxt = sub_q;
		len_nxt = len_q;
		pos_nxt = pos_q;
		res_vld = 1'b0;
		res.kind = asfp_pkg::KIND_DEVICE;
		res.sub_address = '0;
		res.byte_index = pos_q;
		res.body_byte = '0;
		res.last = 1'b0;
		unique case (phase_q)
			PH_ADDR: begin
				if (byte_s1 == asfp_pkg::SYSTEM_ADDR) begin
					sys_nxt = 1'b1;
					phase_nxt = PH_SUB;
				end else if (byte_s1 == cfg.own_address) begin
					sys_nxt = 1'b0;
					phase_nxt = PH_SUB;
				end else begin
					phase_nxt = PH_HUNT;
				end
			end
			PH_SUB: begin
				if (sub_ok) begin
					sub_nxt = byte_s1;
					phase_nxt = PH_LEN;
				end else begin
					phase_nxt = PH_HUNT;
				end
			end
			PH_LEN: begin
				len_nxt = byte_s1;
				pos_nxt = '0;
				ping_nxt = 1'b0;
				// an empty body drops the frame
				phase_nxt = (byte_s1 == '0) ? PH_HUNT : PH_BODY;
			end
			PH_BODY: begin
				ping_nxt = ping_now;
				if (ping_now) begin
					// ping frames yield a single pong request at their last byte
					res_vld = is_last;
					res.kind = asfp_pkg::KIND_PONG;
					res.last = 1'b1;
				end else begin
					res_vld = 1'b1;
					res.kind = sys_q ? asfp_pkg::KIND_SYSTEM : asfp_pkg::KIND_DEVICE;
					res.sub_address = sys_q ? '0 : sub_q;
					res.body_byte = byte_s1;
					res.last = is_last;
				end
				pos_nxt = pos_q + 8'd1;
				if (is_last) begin
					phase_nxt = PH_HUNT;
				end
			end
			default: begin
				phase_nxt = (byte_s1 == cfg.start_marker) ? PH_ADDR : PH_HUNT;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_HUNT;
			sys_q <= 1'b0;
			ping_q <= 1'b0;
			sub_q <= '0;
			len_q <= '0;
			pos_q <= '0;
		end else if (flow.step) begin
			phase_q <= phase_nxt;
			sys_q <= sys_nxt;
			ping_q <= ping_nxt;
			sub_q <= sub_nxt;
			len_q <= len_nxt;
			pos_q <= pos_nxt;
		end
	end

endmodule
`default_nettype wire

// ===== hdl/asfp_out_stage.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// asfp_out_stage
// Result register driving the result channel; loads whenever it is empty or
// its current result is being taken.
// ----------------------------------------------------------------------------
module asfp_out_stage (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           step,
	input  wire logic           res_vld,
	input  wire asfp_pkg::res_t res_d,
	output logic                advance,
	asfp_res_if.source          res
);

	logic           vld_s2;
	asfp_pkg::res_t data_s2;

	assign advance = !vld_s2 || res.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s2 <= 1'b0;
		end else if (advance) begin
			vld_s2 <= step && res_vld;
		end
	end

	always_ff @(posedge clk) begin
		if (step && res_vld) begin
			data_s2 <= res_d;
		end
	end

	assign res.valid = vld_s2;
	assign res.kind = data_s2.kind;
	assign res.sub_address = data_s2.sub_address;
	assign res.byte_index = data_s2.byte_index;
	assign res.body_byte = data_s2.body_byte;
	assign res.last = data_s2.last;

endmodule
`default_nettype wire

// ===== hdl/addressed_serial_frame_parser.sv =====
`timescale 1ns / 1ps
`default_nettype none
// path: each byte is registered in the byte register and its result in the result register
// throughput: one byte per cycle while the result register is not stalled, set by the frame
// state update between the byte register and the result register
// a stalled result register holds one result while one more byte waits
// reset: async active low; parser returns to start hunt, registers to defaults
// ----------------------------------------------------------------------------
// addressed_serial_frame_parser
// Parses addressed serial frames and forwards body bytes or pong requests.
// ----------------------------------------------------------------------------
module addressed_serial_frame_parser (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	asfp_rx_if.sink                             rx,
	asfp_res_if.source                          res,
	input  wire logic                           cfg_we,
	input  wire logic [asfp_pkg::CFG_IDX_W-1:0] cfg_index,
	input  wire asfp_pkg::byte_t                cfg_data
);

	asfp_pkg::cfg_t  cfg;
	asfp_pkg::flow_t flow;
	asfp_pkg::byte_t byte_s1;
	asfp_pkg::res_t  res_d;
	logic            res_vld;
	logic            advance;

	asfp_cfg_regs u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	asfp_in_stage u_in (
		.clk     (clk),
		.arst_n  (arst_n),
		.rx      (rx),
		.advance (advance),
		.flow    (flow),
		.byte_s1 (byte_s1)
	);

	asfp_frame_fsm u_fsm (
		.clk     (clk),
		.arst_n  (arst_n),
		.flow    (flow),
		.byte_s1 (byte_s1),
		.cfg     (cfg),
		.res_vld (res_vld),
		.res     (res_d)
	);

	asfp_out_stage u_out (
		.clk     (clk),
		.arst_n  (arst_n),
		.step    (flow.step),
		.res_vld (res_vld),
		.res_d   (res_d),
		.advance (advance),
		.res     (res)
	);

	a_pong_closes_frame: assert property (@(posedge clk) disable iff (!arst_n)
		res.valid && res.kind == asfp_pkg::KIND_PONG |-> res.last && res.body_byte == '0)
		else $error("pong request without last mark or with a body byte");

	a_system_sub_zero: assert property (@(posedge clk) disable iff (!arst_n)
		res.valid && res.kind != asfp_pkg::KIND_DEVICE |-> res.sub_address == '0)
		else $error("system or pong result carries a sub-address");

	a_ready_when_empty: assert property (@(posedge clk) disable iff (!arst_n)
		!res.valid |-> rx.ready)
		else $error("byte channel stalled while result register is empty");

	a_result_holds: assert property (@(posedge clk) disable iff (!arst_n)
		res.valid && !res.ready |=> res.valid && $stable(res.byte_index)
			&& $stable(res.body_byte))
		else $error("stalled result changed");

endmodule
`default_nettype wire

// ===== tb/testbench.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Drives received bytes into the addressed serial frame parser and checks
// every forwarded body byte and pong request against a cycle-free model of
// the frame parser, over several register settings and random idling.
// ----------------------------------------------------------------------------
module testbench;

	localparam int CYCLE_LIMIT = 500000;
	localparam int SETTLE_CYCLES = 8;
	localparam int HOLDOFF_CYCLES = 120;

	typedef enum logic [2:0] {
		P_HUNT,
		P_ADDR,
		P_SUB,
		P_LEN,
		P_BODY
	} parse_phase_t;

	// frame parser model plus the queue of results still to arrive
	class frame_tracker;
		asfp_pkg::cfg_t regs;
		parse_phase_t phase;
		bit sys_frame;
		bit ping_frame;
		asfp_pkg::byte_t held_sub;
		asfp_pkg::byte_t body_len;
		asfp_pkg::byte_t body_pos;
		asfp_pkg::res_t awaited_results[$];
		int errors;

		function new();
			regs.start_marker = asfp_pkg::RST_START_MARKER;
			regs.own_address = asfp_pkg::RST_OWN_ADDRESS;
			regs.sub_low = asfp_pkg::RST_SUB_LOW;
			regs.sub_high = asfp_pkg::RST_SUB_HIGH;
			regs.ping_code = asfp_pkg::RST_PING_CODE;
			phase = P_HUNT;
			sys_frame = 1'b0;
			ping_frame = 1'b0;
			held_sub = '0;
			body_len = '0;
			body_pos = '0;
			errors = 0;
		endfunction

		function void set_reg(logic [asfp_pkg::CFG_IDX_W-1:0] idx, asfp_pkg::byte_t v);
			case (idx)
				asfp_pkg::CFG_START_MARKER: regs.start_marker = v;
				asfp_pkg::CFG_OWN_ADDRESS: regs.own_address = v;
				asfp_pkg::CFG_SUB_LOW: regs.sub_low = v;
				asfp_pkg::CFG_SUB_HIGH: regs.sub_high = v;
				asfp_pkg::CFG_PING_CODE: regs.ping_code = v;
				default: ;
			endcase
		endfunction

		function void take_byte(asfp_pkg::byte_t b);
			asfp_pkg::res_t r;
			bit is_last;
			case (phase)
				P_ADDR: begin
					if (b == asfp_pkg::SYSTEM_ADDR) begin
						sys_frame = 1'b1;
						phase = P_SUB;
					end else if (b == regs.own_address) begin
						sys_frame = 1'b0;
						phase = P_SUB;
					end else begin
						phase = P_HUNT;
					end
				end
				P_SUB: begin
					if (b == 8'h00 || (b >= regs.sub_low && b <= regs.sub_high)) begin
						held_sub = b;
						phase = P_LEN;
					end else begin
						phase = P_HUNT;
					end
				end
				P_LEN: begin
					body_len = b;
					body_pos = '0;
					ping_frame = 1'b0;
					phase = (b == 8'h00) ? P_HUNT : P_BODY;
				end
				P_BODY: begin
					is_last = ({1'b0, body_pos} + 9'd1) >= {1'b0, body_len};
					if (body_pos == 8'h00)
						ping_frame = sys_frame && (b == regs.ping_code);
					r.byte_index = body_pos;
					r.last = is_last;
					if (ping_frame) begin
						// a ping frame answers once, at its final byte
						if (is_last) begin
							r.kind = asfp_pkg::KIND_PONG;
							r.sub_address = '0;
							r.body_byte = '0;
							awaited_results.push_back(r);
						end
					end else begin
						r.kind = sys_frame ? asfp_pkg::KIND_SYSTEM : asfp_pkg::KIND_DEVICE;
						r.sub_address = sys_frame ? 8'h00 : held_sub;
						r.body_byte = b;
						awaited_results.push_back(r);
					end
					body_pos = body_pos + 8'd1;
					if (is_last)
						phase = P_HUNT;
				end
				default: begin
					phase = (b == regs.start_marker) ? P_ADDR : P_HUNT;
				end
			endcase
		endfunction

		function void match_result(asfp_pkg::res_t got);
			asfp_pkg::res_t want;
			if (awaited_results.size() == 0) begin
				$error("result with none awaited: kind %0d index %0d byte %0d",
					got.kind, got.byte_index, got.body_byte);
				errors++;
				return;
			end
			want = awaited_results.pop_front();
			if (got.kind !== want.kind) begin
				$error("kind: expected %0d, actual %0d", want.kind, got.kind);
				errors++;
			end
			if (got.sub_address !== want.sub_address) begin
				$error("sub_address: expected %0d, actual %0d", want.sub_address,
					got.sub_address);
				errors++;
			end
			if (got.byte_index !== want.byte_index) begin
				$error("byte_index: expected %0d, actual %0d", want.byte_index,
					got.byte_index);
				errors++;
			end
			if (got.body_byte !== want.body_byte) begin
				$error("body_byte: expected %0d, actual %0d", want.body_byte, got.body_byte);
				errors++;
			end
			if (got.last !== want.last) begin
				$error("last: expected %0d, actual %0d", want.last, got.last);
				errors++;
			end
		endfunction
	endclass

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_we;
	logic [asfp_pkg::CFG_IDX_W-1:0] cfg_index;
	asfp_pkg::byte_t cfg_data;

	asfp_rx_if rx_ch ();
	asfp_res_if res_ch ();

	frame_tracker tracker = new();
	bit gaps_on = 1'b1;
	bit hold_request = 1'b0;
	int hold_left = 0;
	int frame_items = 0;
	int cycle_count = 0;

	addressed_serial_frame_parser dut (
		.clk(clk),
		.arst_n(arst_n),
		.rx(rx_ch),
		.res(res_ch),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("Some tests failed");
			$finish;
		end
	end

	// result side: check each transfer, then pick next cycle's ready
	always @(posedge clk) begin
		asfp_pkg::res_t got;
		if (arst_n && res_ch.valid === 1'b1 && res_ch.ready === 1'b1) begin
			got.kind = asfp_pkg::kind_t'(res_ch.kind);
			got.sub_address = res_ch.sub_address;
			got.byte_index = res_ch.byte_index;
			got.body_byte = res_ch.body_byte;
			got.last = res_ch.last;
			tracker.match_result(got);
		end
		if (hold_request) begin
			hold_left = HOLDOFF_CYCLES;
			hold_request = 1'b0;
		end
		if (hold_left > 0) begin
			hold_left--;
			res_ch.ready <= 1'b0;
		end else begin
			res_ch.ready <= !(gaps_on && $urandom_range(99) < 32);
		end
	end

	task automatic send_byte(input asfp_pkg::byte_t b, input bit counted);
		while (gaps_on && $urandom_range(99) < 32) begin
			rx_ch.valid <= 1'b0;
			@(posedge clk);
		end
		rx_ch.valid <= 1'b1;
		rx_ch.rx_byte <= b;
		do
			@(posedge clk);
		while (rx_ch.ready !== 1'b1);
		tracker.take_byte(b);
		if (counted)
			frame_items++;
	endtask

	task automatic send_bytes(input asfp_pkg::byte_t seq[$]);
		foreach (seq[i])
			send_byte(seq[i], 1'b1);
	endtask

	// stop offering and let the parser empty out before touching registers
	task automatic drain();
		rx_ch.valid <= 1'b0;
		while (tracker.awaited_results.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic program_regs(input asfp_pkg::cfg_t c);
		asfp_pkg::byte_t vals[5];
		vals[asfp_pkg::CFG_START_MARKER] = c.start_marker;
		vals[asfp_pkg::CFG_OWN_ADDRESS] = c.own_address;
		vals[asfp_pkg::CFG_SUB_LOW] = c.sub_low;
		vals[asfp_pkg::CFG_SUB_HIGH] = c.sub_high;
		vals[asfp_pkg::CFG_PING_CODE] = c.ping_code;
		for (int i = 0; i < 5; i++) begin
			cfg_we <= 1'b1;
			cfg_index <= asfp_pkg::CFG_IDX_W'(i);
			cfg_data <= vals[i];
			tracker.set_reg(asfp_pkg::CFG_IDX_W'(i), vals[i]);
			@(posedge clk);
		end
		cfg_we <= 1'b0;
	endtask

	// mostly well-formed frames with random content; some dropped or cut short
	task automatic send_frame();
		asfp_pkg::byte_t frame_q[$];
		asfp_pkg::byte_t addr;
		asfp_pkg::byte_t sub;
		asfp_pkg::byte_t len;
		int pick;
		int cut;
		pick = $urandom_range(99);
		if (pick < 40)
			addr = tracker.regs.own_address;
		else if (pick < 75)
			addr = asfp_pkg::SYSTEM_ADDR;
		else
			addr = asfp_pkg::byte_t'($urandom_range(255));
		pick = $urandom_range(99);
		if (pick < 30)
			sub = 8'h00;
		else if (pick < 85 && tracker.regs.sub_low <= tracker.regs.sub_high)
			sub = asfp_pkg::byte_t'($urandom_range(tracker.regs.sub_high,
				tracker.regs.sub_low));
		else
			sub = asfp_pkg::byte_t'($urandom_range(255));
		pick = $urandom_range(99);
		if (pick < 5)
			len = 8'h00;
		else if (pick < 10)
			len = asfp_pkg::byte_t'($urandom_range(40, 9));
		else
			len = asfp_pkg::byte_t'($urandom_range(8, 1));
		frame_q = '{tracker.regs.start_marker, addr, sub, len};
		for (int i = 0; i < len; i++) begin
			if (i == 0 && $urandom_range(1))
				frame_q.push_back(tracker.regs.ping_code);
			else
				frame_q.push_back(asfp_pkg::byte_t'($urandom_range(255)));
		end
		cut = frame_q.size();
		if ($urandom_range(99) < 5)
			cut = $urandom_range(frame_q.size() - 1, 1);
		for (int i = 0; i < cut; i++)
			send_byte(frame_q[i], 1'b1);
	endtask

	task automatic run_frames(input int item_goal);
		while (frame_items < item_goal) begin
			if ($urandom_range(99) < 15) begin
				repeat ($urandom_range(3, 1))
					send_byte(asfp_pkg::byte_t'($urandom_range(255)), 1'b0);
			end
			send_frame();
		end
	endtask

	initial begin
		asfp_pkg::cfg_t c;
		asfp_pkg::byte_t long_q[$];
		rx_ch.valid <= 1'b0;
		rx_ch.rx_byte <= '0;
		cfg_we <= 1'b0;
		cfg_index <= asfp_pkg::CFG_START_MARKER;
		cfg_data <= '0;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// device frame with extreme body bytes
		send_bytes('{asfp_pkg::RST_START_MARKER, asfp_pkg::RST_OWN_ADDRESS, 8'd5, 8'd2,
			8'h00, 8'hff});
		// system ping answered by a pong
		send_bytes('{asfp_pkg::RST_START_MARKER, asfp_pkg::SYSTEM_ADDR, 8'h00, 8'd1,
			asfp_pkg::RST_PING_CODE});
		// zero-length body is dropped
		send_bytes('{asfp_pkg::RST_START_MARKER, asfp_pkg::RST_OWN_ADDRESS, 8'h00, 8'h00});
		// foreign address
		send_bytes('{asfp_pkg::RST_START_MARKER, 8'd9});
		// system frame, start marker as body byte, sub-address reported as zero
		send_bytes('{asfp_pkg::RST_START_MARKER, asfp_pkg::SYSTEM_ADDR, 8'd3, 8'd2,
			asfp_pkg::RST_START_MARKER, 8'hff});
		run_frames(180);
		drain();

		c.start_marker = 8'h00;
		c.own_address = 8'hff;
		c.sub_low = 8'h01;
		c.sub_high = 8'hff;
		c.ping_code = 8'h00;
		program_regs(c);
		run_frames(320);
		drain();

		// empty sub-address range: only zero gets through
		c.start_marker = 8'hff;
		c.own_address = 8'h01;
		c.sub_low = 8'hff;
		c.sub_high = 8'h01;
		c.ping_code = 8'hff;
		program_regs(c);
		long_q = '{8'hff, 8'h01, 8'h00, 8'hff};
		repeat (255)
			long_q.push_back(asfp_pkg::byte_t'($urandom_range(255)));
		send_bytes(long_q);
		run_frames(560);
		drain();

		// no idling on either side, with one long result stall up front
		c.start_marker = asfp_pkg::byte_t'($urandom_range(255));
		c.own_address = asfp_pkg::byte_t'($urandom_range(255, 1));
		c.sub_low = asfp_pkg::byte_t'($urandom_range(255, 1));
		c.sub_high = asfp_pkg::byte_t'($urandom_range(255, 1));
		c.ping_code = asfp_pkg::byte_t'($urandom_range(255));
		program_regs(c);
		gaps_on = 1'b0;
		hold_request = 1'b1;
		run_frames(680);
		drain();
		gaps_on = 1'b1;

		c.start_marker = asfp_pkg::byte_t'($urandom_range(255));
		c.own_address = asfp_pkg::byte_t'($urandom_range(255, 1));
		c.sub_low = asfp_pkg::byte_t'($urandom_range(40, 1));
		c.sub_high = asfp_pkg::byte_t'($urandom_range(255, 200));
		c.ping_code = asfp_pkg::byte_t'($urandom_range(255));
		program_regs(c);
		run_frames(780);
		drain();

		// single-value sub-address range
		c.sub_low = asfp_pkg::byte_t'($urandom_range(255, 1));
		c.sub_high = c.sub_low;
		c.own_address = asfp_pkg::byte_t'($urandom_range(255, 1));
		program_regs(c);
		run_frames(850);
		drain();

		if (tracker.errors == 0)
			$display("All tests passed");
		else
			$display("Some tests failed");
		$finish;
	end

endmodule

// ===== sim.f =====
hdl/asfp_pkg.sv
hdl/asfp_rx_if.sv
hdl/asfp_res_if.sv
hdl/asfp_cfg_regs.sv
hdl/asfp_in_stage.sv
hdl/asfp_frame_fsm.sv
hdl/asfp_out_stage.sv
hdl/addressed_serial_frame_parser.sv
tb/testbench.sv
